[rtl/ethernet_ipv4_header_classifier_defines.svh]
// Assertion helpers shared by the classifier RTL.
`ifndef ETHERNET_IPV4_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_IPV4_HEADER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EHC_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("ehc assertion failed");

// Next-cycle implication, disabled while in reset.
`define EHC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("ehc assertion failed");

`endif

[rtl/ehc_pkg.sv]
package ehc_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
  localparam logic [5:0]  MIN_IHL_BYTES  = 6'd20;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;

  // byte offsets within the frame
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL      = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SRC_LO   = 16'd26;
  localparam logic [15:0] POS_SRC_HI   = 16'd29;
  localparam logic [15:0] POS_DST_LO   = 16'd30;
  localparam logic [15:0] POS_DST_HI   = 16'd33;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_RECORDED  = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_NOT_IPV4  = 2'd2,
    ST_SHORT_HDR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_TCP   = 2'd0,
    CL_UDP   = 2'd1,
    CL_ICMP  = 2'd2,
    CL_OTHER = 2'd3
  } class_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] wire_length;
  } beat_t;

  typedef struct packed {
    status_t     parse_status;
    class_t      protocol_class;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [63:0] frames_seen;
    logic [63:0] wire_bytes_seen;
  } result_t;

endpackage

[rtl/ehc_parser.sv]
module ehc_parser
  import ehc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    beat_fire,
  input  beat_t   beat,
  output result_t res
);

  logic [15:0] pos_r;
  logic [15:0] etype_r;
  logic [5:0]  hdr_bytes_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [63:0] frame_cnt_r;
  logic [63:0] byte_cnt_r;

  logic [15:0] etype_nxt;
  logic [5:0]  hdr_bytes_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] src_nxt;
  logic [31:0] dst_nxt;
  logic [15:0] sport_nxt;
  logic [15:0] dport_nxt;
  logic [63:0] frame_cnt_nxt;
  logic [63:0] byte_cnt_nxt;

  logic [15:0] l4_off;
  logic [15:0] l4_hdr_bytes;
  logic        ports_ok;
  logic [7:0]  b;

  assign b = beat.frame_byte;

  // capture of the current byte, applied before classification
  always_comb begin
    etype_nxt     = etype_r;
    hdr_bytes_nxt = hdr_bytes_r;
    proto_nxt     = proto_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    sport_nxt     = sport_r;
    dport_nxt     = dport_r;
    l4_off        = ETH_HDR_LEN + {10'd0, hdr_bytes_r};
    if (pos_r == POS_ETYPE_HI || pos_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_r[7:0], b};
    end
    if (pos_r == POS_IHL) begin
      hdr_bytes_nxt = {b[3:0], 2'b00};
    end
    if (pos_r == POS_PROTO) begin
      proto_nxt = b;
    end
    if (pos_r >= POS_SRC_LO && pos_r <= POS_SRC_HI) begin
      src_nxt = {src_r[23:0], b};
    end
    if (pos_r >= POS_DST_LO && pos_r <= POS_DST_HI) begin
      dst_nxt = {dst_r[23:0], b};
    end
    // ports only once the header length is known
    if (pos_r > POS_IHL) begin
      if (pos_r >= l4_off && pos_r < l4_off + 16'd2) begin
        sport_nxt = {sport_r[7:0], b};
      end else if (pos_r >= l4_off + 16'd2 && pos_r < l4_off + 16'd4) begin
        dport_nxt = {dport_r[7:0], b};
      end
    end
  end

  // captured length = pos + 1; compare on pos to stay in 16 bits
  assign l4_hdr_bytes  = ETH_HDR_LEN + 16'd3 + {10'd0, hdr_bytes_nxt};
  assign ports_ok      = pos_r >= l4_hdr_bytes;
  assign frame_cnt_nxt = frame_cnt_r + 64'd1;
  assign byte_cnt_nxt  = byte_cnt_r + {48'd0, beat.wire_length};

  always_comb begin
    res                     = '0;
    res.parse_status        = ST_RECORDED;
    res.protocol_class      = CL_OTHER;
    res.frames_seen         = frame_cnt_nxt;
    res.wire_bytes_seen     = byte_cnt_nxt;
    priority if (pos_r < MIN_FRAME_LEN - 16'd1) begin
      res.parse_status = ST_TOO_SHORT;
    end else if (etype_nxt != ETHERTYPE_IPV4) begin
      res.parse_status = ST_NOT_IPV4;
    end else if (hdr_bytes_nxt < MIN_IHL_BYTES) begin
      res.parse_status = ST_SHORT_HDR;
    end else begin
      res.source_address      = src_nxt;
      res.destination_address = dst_nxt;
      priority if (proto_nxt == PROTO_TCP && ports_ok) begin
        res.protocol_class   = CL_TCP;
        res.source_port      = sport_nxt;
        res.destination_port = dport_nxt;
      end else if (proto_nxt == PROTO_UDP && ports_ok) begin
        res.protocol_class   = CL_UDP;
        res.source_port      = sport_nxt;
        res.destination_port = dport_nxt;
      end else if (proto_nxt == PROTO_ICMP) begin
        res.protocol_class = CL_ICMP;
      end else begin
        res.protocol_class = CL_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      etype_r     <= '0;
      hdr_bytes_r <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      frame_cnt_r <= '0;
      byte_cnt_r  <= '0;
    end else if (beat_fire) begin
      if (beat.frame_last) begin
        pos_r       <= '0;
        etype_r     <= '0;
        hdr_bytes_r <= '0;
        proto_r     <= '0;
        src_r       <= '0;
        dst_r       <= '0;
        sport_r     <= '0;
        dport_r     <= '0;
        frame_cnt_r <= frame_cnt_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
      end else begin
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 16'd1;
        end
        etype_r     <= etype_nxt;
        hdr_bytes_r <= hdr_bytes_nxt;
        proto_r     <= proto_nxt;
        src_r       <= src_nxt;
        dst_r       <= dst_nxt;
        sport_r     <= sport_nxt;
        dport_r     <= dport_nxt;
      end
    end
  end

endmodule

[rtl/ethernet_ipv4_header_classifier.sv]
// Path: a last byte is held in the stage-1 input register, then its result in the output register on out_*.
// Throughput: one byte per cycle; a last byte stalls only while the output
// register still holds an untaken result.
// Reset: synchronous, active-low rst_n clears the pipeline valids, per-frame
// capture state and both 64-bit counters; no clearing pass.
`include "ethernet_ipv4_header_classifier_defines.svh"

module ethernet_ipv4_header_classifier
  import ehc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  input  logic [15:0] in_wire_length,
  // one beat per frame out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_parse_status,
  output logic [1:0]  out_protocol_class,
  output logic [31:0] out_source_address,
  output logic [31:0] out_destination_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [63:0] out_frames_seen,
  output logic [63:0] out_wire_bytes_seen
);

  // Stage 1: input register holding one byte beat.
  logic    s1_valid_r;
  beat_t   s1_beat_r;
  // Stage 2: output register holding the frame result.
  logic    out_valid_r;
  result_t out_res_r;

  logic    out_free;   // output register can load this cycle
  logic    s1_fire;    // stage-1 beat consumed by the parser
  logic    in_fire;
  result_t parse_res;

  assign out_free = !out_valid_r || out_ready;
  // non-last bytes never need the output register, so they always drain
  assign s1_fire  = s1_valid_r && (!s1_beat_r.frame_last || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  ehc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (s1_fire),
    .beat      (s1_beat_r),
    .res       (parse_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r.frame_byte  <= in_frame_byte;
      s1_beat_r.frame_last  <= in_frame_last;
      s1_beat_r.wire_length <= in_wire_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_beat_r.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_beat_r.frame_last) begin
      out_res_r <= parse_res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_parse_status        = out_res_r.parse_status;
  assign out_protocol_class      = out_res_r.protocol_class;
  assign out_source_address      = out_res_r.source_address;
  assign out_destination_address = out_res_r.destination_address;
  assign out_source_port         = out_res_r.source_port;
  assign out_destination_port    = out_res_r.destination_port;
  assign out_frames_seen         = out_res_r.frames_seen;
  assign out_wire_bytes_seen     = out_res_r.wire_bytes_seen;

  // Back-pressure only comes from a last byte blocked on a full output register.
  `EHC_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready, s1_valid_r && s1_beat_r.frame_last && out_valid_r && !out_ready)
  // Rejected frames carry no addresses and class OTHER.
  `EHC_ASSERT_SAME(a_reject_clean, clk, rst_n, out_valid_r && out_res_r.parse_status != ST_RECORDED, out_res_r.protocol_class == CL_OTHER && out_res_r.source_address == 32'd0 && out_res_r.destination_address == 32'd0)
  // Ports only for TCP or UDP.
  `EHC_ASSERT_SAME(a_ports_l4, clk, rst_n, out_valid_r && (out_res_r.protocol_class == CL_ICMP || out_res_r.protocol_class == CL_OTHER), out_res_r.source_port == 16'd0 && out_res_r.destination_port == 16'd0)
  // A non-last byte never produces a result.
  `EHC_ASSERT_NEXT(a_no_mid_result, clk, rst_n, s1_fire && !s1_beat_r.frame_last && !out_valid_r, !out_valid_r)

endmodule
